FILE: sv/drp_pkg.sv
package drp_pkg;

    // Register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_FOCAL    = 2'd0;
    localparam logic [1:0] REG_BASELINE = 2'd1;
    localparam logic [1:0] REG_WIDTH    = 2'd2;
    localparam logic [1:0] REG_HEIGHT   = 2'd3;

    // Field widths
    localparam int FOCAL_W = 16;
    localparam int BASE_W  = 20;
    localparam int DIM_W   = 13;
    localparam int DISP_W  = 16;
    localparam int DMAG_W  = 15;
    localparam int LAT_W   = 32;
    localparam int Z_W     = 31;
    localparam int TDATA_W = 96;

    // Reset values
    localparam logic [FOCAL_W-1:0] FOCAL_RST    = 16'd7680;
    localparam logic [BASE_W-1:0]  BASELINE_RST = 20'd6554;
    localparam logic [DIM_W-1:0]   WIDTH_RST    = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RST   = 13'd480;

    // Default frame limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal;
        logic [BASE_W-1:0]  baseline;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } cfg_t;

endpackage

FILE: sv/drp_regs.sv
module drp_regs
    import drp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FOCAL:    cfg_next.focal        = pwdata[FOCAL_W-1:0];
                REG_BASELINE: cfg_next.baseline     = pwdata[BASE_W-1:0];
                REG_WIDTH:    cfg_next.image_width  = pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_next.image_height = pwdata[DIM_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FOCAL:    prdata = DATA_W'(cfg_reg.focal);
            REG_BASELINE: prdata = DATA_W'(cfg_reg.baseline);
            REG_WIDTH:    prdata = DATA_W'(cfg_reg.image_width);
            REG_HEIGHT:   prdata = DATA_W'(cfg_reg.image_height);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal        <= FOCAL_RST;
            cfg_reg.baseline     <= BASELINE_RST;
            cfg_reg.image_width  <= WIDTH_RST;
            cfg_reg.image_height <= HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/drp_div.sv
module drp_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

FILE: sv/disparity_to_point_reprojection_core.sv
// A positive disparity with nonzero focal length runs S_MUL, S_START and S_WAIT for Z,
// X and Y in turn on the shared restoring divider (one quotient bit per cycle), then S_OUT;
// other items go straight to S_OUT, which waits until the output register is free. s_tready
// is high only in S_IDLE, so a new item is taken only once the last is in the output register.
// Reset: asynchronous, active low; registers take their reset values and the
// column and row counters clear to zero.
module disparity_to_point_reprojection_core
    import drp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // Disparity input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DISP_W-1:0]  s_tdata,   // [15:0] disparity
    // Point output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] point_x, [63:32] point_y,
                                          // [94:64] point_z, [95] zero pad
    output logic               m_tuser,   // [0] point_valid
    output logic               m_tlast    // frame_last
);

    // Widths that follow from the frame limits
    localparam int WEW  = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int HEW  = $clog2(MAX_HEIGHT + 1);   // effective height
    localparam int CXW  = $clog2(MAX_WIDTH);        // column counter
    localparam int CYW  = $clog2(MAX_HEIGHT);       // row counter
    localparam int WCW  = (DIM_W > WEW) ? DIM_W : WEW;
    localparam int HCW  = (DIM_W > HEW) ? DIM_W : HEW;
    localparam int MGW  = ((WEW > HEW) ? WEW : HEW) + 1;   // |2*pos - dim|
    localparam int MAW  = (FOCAL_W > MGW) ? FOCAL_W : MGW;  // multiplier operand
    localparam int PW   = MAW + BASE_W;
    localparam int NW_Z = FOCAL_W + BASE_W;
    localparam int NW_L = MGW + BASE_W + 3;
    localparam int NUM_W = (NW_Z > NW_L) ? NW_Z : NW_L;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        J_Z,
        J_X,
        J_Y
    } job_t;

    cfg_t cfg;

    drp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [CXW-1:0]     col_reg, col_next;
    logic [CYW-1:0]     row_reg, row_next;
    logic [MGW-1:0]     magx_reg, magx_next;
    logic [MGW-1:0]     magy_reg, magy_next;
    logic               negx_reg, negx_next;
    logic               negy_reg, negy_next;
    logic [DMAG_W-1:0]  den_reg, den_next;
    logic               valid_reg, valid_next;
    logic               flast_reg, flast_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [Z_W-1:0]     z_reg, z_next;
    logic [LAT_W-1:0]   x_reg, x_next;
    logic [LAT_W-1:0]   y_reg, y_next;
    logic               ovalid_reg, ovalid_next;
    logic [Z_W-1:0]     oz_reg, oz_next;
    logic [LAT_W-1:0]   ox_reg, ox_next;
    logic [LAT_W-1:0]   oy_reg, oy_next;
    logic               ouser_reg, ouser_next;
    logic               olast_reg, olast_next;

    // Effective frame size: clamp the registers to 1..MAX
    logic [WCW-1:0] w_ext;
    logic [HCW-1:0] h_ext;
    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;

    assign w_ext = WCW'(cfg.image_width);
    assign h_ext = HCW'(cfg.image_height);
    assign w_eff = (w_ext == '0) ? WEW'(1) :
                   (w_ext > WCW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : w_ext[WEW-1:0];
    assign h_eff = (h_ext == '0) ? HEW'(1) :
                   (h_ext > HCW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : h_ext[HEW-1:0];

    // Position flags and center offsets in half pixels for the pixel at the counters
    logic           row_end, row_last;
    logic [WEW:0]   two_u, wx;
    logic [HEW:0]   two_v, hy;
    logic [WEW:0]   magx_c;
    logic [HEW:0]   magy_c;

    assign row_end  = (WEW'(col_reg) + WEW'(1)) >= w_eff;
    assign row_last = (HEW'(row_reg) + HEW'(1)) >= h_eff;
    assign two_u    = (WEW + 1)'(col_reg) << 1;
    assign wx       = (WEW + 1)'(w_eff);
    assign two_v    = (HEW + 1)'(row_reg) << 1;
    assign hy       = (HEW + 1)'(h_eff);
    assign magx_c   = (two_u >= wx) ? (two_u - wx) : (wx - two_u);
    assign magy_c   = (two_v >= hy) ? (two_v - hy) : (hy - two_v);

    // Disparity must be strictly positive to give a point
    logic disp_pos;
    logic accept;

    assign disp_pos = !s_tdata[DISP_W-1] && (s_tdata[DMAG_W-1:0] != '0);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Shared multiplier operand: F for depth, |offset| for the lateral terms
    logic [MAW-1:0] mul_a;

    always_comb
    begin
        case (job_reg)
            J_Z:     mul_a = MAW'(cfg.focal);
            J_X:     mul_a = MAW'(magx_reg);
            J_Y:     mul_a = MAW'(magy_reg);
            default: mul_a = '0;
        endcase
    end

    // Shared divider; lateral numerators carry the extra factor of 8
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] quot;

    assign div_start = (state_reg == S_START);
    assign div_num   = (job_reg == J_Z) ? NUM_W'(prod_reg) : (NUM_W'(prod_reg) << 3);

    drp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DMAG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Saturate the quotient to the output fields
    logic           q_hi31;     // quotient >= 2^31
    logic           q_over_neg; // quotient > 2^31
    logic [Z_W-1:0] z_sat;
    logic           lat_neg;
    logic [LAT_W-1:0] lat_sat;

    assign q_hi31     = (quot[NUM_W-1:Z_W] != '0);
    assign q_over_neg = (quot[NUM_W-1:LAT_W] != '0) || (quot[Z_W] && (quot[Z_W-1:0] != '0));
    assign z_sat      = q_hi31 ? {Z_W{1'b1}} : quot[Z_W-1:0];
    assign lat_neg    = (job_reg == J_X) ? negx_reg : negy_reg;

    always_comb
    begin
        if (lat_neg)
        begin
            lat_sat = q_over_neg ? {1'b1, {(LAT_W-1){1'b0}}} : (LAT_W'(0) - quot[LAT_W-1:0]);
        end
        else
        begin
            lat_sat = q_hi31 ? {1'b0, {(LAT_W-1){1'b1}}} : quot[LAT_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        magx_next   = magx_reg;
        magy_next   = magy_reg;
        negx_next   = negx_reg;
        negy_next   = negy_reg;
        den_next    = den_reg;
        valid_next  = valid_reg;
        flast_next  = flast_reg;
        prod_next   = prod_reg;
        z_next      = z_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ovalid_next = ovalid_reg;
        oz_next     = oz_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;

        // Drop the output item once taken
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Latch the pixel position, then advance the counters
                    magx_next  = MGW'(magx_c);
                    magy_next  = MGW'(magy_c);
                    negx_next  = two_u < wx;
                    negy_next  = two_v < hy;
                    den_next   = s_tdata[DMAG_W-1:0];
                    valid_next = disp_pos;
                    flast_next = row_end && row_last;
                    z_next     = '0;
                    x_next     = '0;
                    y_next     = '0;
                    job_next   = J_Z;
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = row_last ? '0 : (row_reg + CYW'(1));
                    end
                    else
                    begin
                        col_next = col_reg + CXW'(1);
                    end
                    // Zero focal length or no positive disparity: all coordinates zero
                    if (disp_pos && (cfg.focal != '0))
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(mul_a) * PW'(cfg.baseline);
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    case (job_reg)
                        J_Z:
                        begin
                            z_next     = z_sat;
                            job_next   = J_X;
                            state_next = S_MUL;
                        end
                        J_X:
                        begin
                            x_next     = lat_sat;
                            job_next   = J_Y;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            y_next     = lat_sat;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    oz_next     = z_reg;
                    ox_next     = x_reg;
                    oy_next     = y_reg;
                    ouser_next  = valid_reg;
                    olast_next  = flast_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            job_reg    <= J_Z;
            col_reg    <= '0;
            row_reg    <= '0;
            magx_reg   <= '0;
            magy_reg   <= '0;
            negx_reg   <= 1'b0;
            negy_reg   <= 1'b0;
            den_reg    <= '0;
            valid_reg  <= 1'b0;
            flast_reg  <= 1'b0;
            prod_reg   <= '0;
            z_reg      <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            ovalid_reg <= 1'b0;
            oz_reg     <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            ouser_reg  <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            job_reg    <= job_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            magx_reg   <= magx_next;
            magy_reg   <= magy_next;
            negx_reg   <= negx_next;
            negy_reg   <= negy_next;
            den_reg    <= den_next;
            valid_reg  <= valid_next;
            flast_reg  <= flast_next;
            prod_reg   <= prod_next;
            z_reg      <= z_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            ovalid_reg <= ovalid_next;
            oz_reg     <= oz_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            ouser_reg  <= ouser_next;
            olast_reg  <= olast_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, oz_reg, oy_reg, ox_reg};
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import drp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    // A positive disparity passes through the shared divider for Z, X and Y in turn.
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam longint LAT_MAX  = 64'sd2147483647;
    localparam longint LAT_MIN  = -64'sd2147483648;

    // One reprojected point as it leaves the block.
    typedef struct {
        logic [LAT_W-1:0] x;
        logic [LAT_W-1:0] y;
        logic [Z_W-1:0]   z;
        logic             valid;
        logic             last;
    } point_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    logic [DISP_W-1:0]  s_tdata;   // [15:0] disparity
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // [31:0] point_x, [63:32] point_y, [94:64] point_z
    logic               m_tuser;   // [0] point_valid
    logic               m_tlast;   // frame_last

    // Shadow copy of the register file and the pixel position counters.
    logic [FOCAL_W-1:0] focal_q;
    logic [BASE_W-1:0]  baseline_q;
    logic [DIM_W-1:0]   width_q;
    logic [DIM_W-1:0]   height_q;
    int                 col_pos;
    int                 row_pos;

    // Points still owed by the block, oldest first.
    point_t point_queue[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_request      = 0;

    int mismatches       = 0;
    int pixels_sent      = 0;
    int points_checked   = 0;
    int frame_ends       = 0;
    int invalid_points   = 0;
    int saturated_points = 0;
    int frame_setups     = 0;

    disparity_to_point_reprojection_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF) clk = ~clk;
        end
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #(4_000_000);
        $display("Timeout: %0d points still outstanding", point_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp a raw dimension register to 1..limit.
    function automatic longint clamp_dim(logic [DIM_W-1:0] raw, int limit);
        if (raw == '0)
        begin
            return 1;
        end
        if (raw > limit)
        begin
            return longint'(limit);
        end
        return longint'(raw);
    endfunction

    // Lateral offset in Q16.16: the focal length cancels, so only
    // (2*pos - dim) * 8 * baseline / disparity remains. Truncate, then saturate.
    function automatic longint lateral_metres(longint offset, longint disp);
        longint quot;
        quot = offset * 8 * longint'(baseline_q) / disp;
        if (quot > LAT_MAX)
        begin
            return LAT_MAX;
        end
        if (quot < LAT_MIN)
        begin
            return LAT_MIN;
        end
        return quot;
    endfunction

    // Work out the point for one pixel and advance the raster position.
    function automatic point_t reproject_pixel(logic [DISP_W-1:0] code);
        point_t pt;
        longint w;
        longint h;
        longint disp;
        longint x;
        longint y;
        longint z;
        bit     row_end;
        bit     row_last;
        w        = clamp_dim(width_q, MAX_WIDTH_DEF);
        h        = clamp_dim(height_q, MAX_HEIGHT_DEF);
        disp     = longint'($signed(code));
        row_end  = (col_pos + 1 >= w);
        row_last = (row_pos + 1 >= h);
        x = 0;
        y = 0;
        z = 0;
        // Non-positive disparity marks an invalid point with zero coordinates;
        // a zero focal length forces Z, and with it X and Y, to zero.
        if (disp > 0 && focal_q != '0)
        begin
            z = longint'(focal_q) * longint'(baseline_q) / disp;
            if (z > LAT_MAX)
            begin
                z = LAT_MAX;
            end
            x = lateral_metres(2 * col_pos - w, disp);
            y = lateral_metres(2 * row_pos - h, disp);
        end
        pt.x     = x[LAT_W-1:0];
        pt.y     = y[LAT_W-1:0];
        pt.z     = z[Z_W-1:0];
        pt.valid = (disp > 0);
        pt.last  = row_end && row_last;
        if (disp <= 0)
        begin
            invalid_points++;
        end
        if (z == LAT_MAX || x == LAT_MAX || x == LAT_MIN || y == LAT_MAX || y == LAT_MIN)
        begin
            saturated_points++;
        end
        // A counter at or past a freshly lowered limit wraps on this pixel.
        if (row_end)
        begin
            col_pos = 0;
            row_pos = row_last ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_point();
        point_t want;
        if (point_queue.size() == 0)
        begin
            note_mismatch("point with nothing pending", '0, m_tdata[63:0]);
        end
        else
        begin
            want = point_queue.pop_front();
            if (m_tdata[31:0] !== want.x)
            begin
                note_mismatch("point_x", 64'(want.x), 64'(m_tdata[31:0]));
            end
            if (m_tdata[63:32] !== want.y)
            begin
                note_mismatch("point_y", 64'(want.y), 64'(m_tdata[63:32]));
            end
            if (m_tdata[94:64] !== want.z)
            begin
                note_mismatch("point_z", 64'(want.z), 64'(m_tdata[94:64]));
            end
            if (m_tuser !== want.valid)
            begin
                note_mismatch("point_valid", 64'(want.valid), 64'(m_tuser));
            end
            if (m_tlast !== want.last)
            begin
                note_mismatch("frame_last", 64'(want.last), 64'(m_tlast));
            end
        end
        points_checked++;
        if (m_tlast === 1'b1)
        begin
            frame_ends++;
        end
    endtask

    // Compare every point the block hands over.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            check_point();
        end
    end

    // Drive the output ready: a requested hold-off first, else random stalls.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Bus tasks (enter and leave just after a falling edge)
    // ------------------------------------------------------------------

    task automatic apb_access(bit is_write, logic [1:0] idx, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        // Setup cycle.
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(negedge clk);
        // Access cycle; hold until the slave is ready.
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_reg(logic [1:0] idx, logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== want)
        begin
            note_mismatch($sformatf("register %0d readback", idx), 64'(want), 64'(rdata));
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] unused;
        logic [DATA_W-1:0] stored;
        stored = '0;
        case (idx)
            REG_FOCAL:
            begin
                focal_q = value[FOCAL_W-1:0];
                stored  = DATA_W'(focal_q);
            end
            REG_BASELINE:
            begin
                baseline_q = value[BASE_W-1:0];
                stored     = DATA_W'(baseline_q);
            end
            REG_WIDTH:
            begin
                width_q = value[DIM_W-1:0];
                stored  = DATA_W'(width_q);
            end
            REG_HEIGHT:
            begin
                height_q = value[DIM_W-1:0];
                stored   = DATA_W'(height_q);
            end
            default:
            begin
            end
        endcase
        apb_access(1'b1, idx, value, unused);
        check_reg(idx, stored);
    endtask

    // Offer one disparity item; predict its point once the block takes it.
    task automatic send_disparity(logic [DISP_W-1:0] code);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        do @(posedge clk); while (!s_tready);
        point_queue.push_back(reproject_pixel(code));
        pixels_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every pending point has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (point_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    // Reprogram the whole register file once the block is idle.
    task automatic set_frame(int focal, int base, int w, int h);
        wait_drained();
        write_reg(REG_FOCAL, focal);
        write_reg(REG_BASELINE, base);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        frame_setups++;
    endtask

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------

    function automatic logic [DISP_W-1:0] pick_disparity();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return {1'b1, 15'($urandom)};
        end
        if (r < 15)
        begin
            return '0;
        end
        if (r < 35)
        begin
            return DISP_W'($urandom_range(1, 64));
        end
        if (r < 45)
        begin
            return DISP_W'($urandom_range(32000, 32767));
        end
        return {1'b0, 15'($urandom_range(1, 32767))};
    endfunction

    function automatic logic [DISP_W-1:0] pick_nonpositive();
        if ($urandom_range(3) == 0)
        begin
            return '0;
        end
        return {1'b1, 15'($urandom)};
    endfunction

    // Mostly small frames so that frame ends come often; now and then an extreme.
    function automatic int pick_dim(int typical);
        case ($urandom_range(19))
            0:       return 0;
            1:       return 8191;
            2:       return MAX_WIDTH_DEF;
            3:       return $urandom_range(1, 8191);
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    function automatic int pick_scale(int full);
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return full;
            3:       return $urandom_range(1, 8191);
            default: return $urandom_range(1, full);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers read back their reset values; extremes of the disparity
    // at the reset geometry.
    task automatic test_reset_state();
        check_reg(REG_FOCAL, DATA_W'(FOCAL_RST));
        check_reg(REG_BASELINE, DATA_W'(BASELINE_RST));
        check_reg(REG_WIDTH, DATA_W'(WIDTH_RST));
        check_reg(REG_HEIGHT, DATA_W'(HEIGHT_RST));
        send_disparity(16'h7FFF);
        send_disparity(16'h8000);
        send_disparity(16'h0000);
        send_disparity(16'h0001);
        send_disparity(16'hFFFF);
        send_disparity(16'h0010);
        send_disparity(16'h0100);
    endtask

    // Clamped dimensions, and counters left past a lowered width or height.
    task automatic test_dimension_limits();
        // Zero width and height clamp to one: every pixel ends a frame.
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), 0, 0);
        send_disparity(16'h0020);
        send_disparity(16'h8001);
        // Oversized registers clamp to the frame limit.
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), 8191, 8191);
        send_disparity(16'h0001);
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), MAX_WIDTH_DEF, MAX_HEIGHT_DEF);
        repeat (6) send_disparity(pick_disparity());
        // Lower the width under the column counter: it wraps on the next pixel.
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), 3, MAX_HEIGHT_DEF);
        repeat (4) send_disparity(pick_disparity());
        // Same for the row counter.
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), 1, MAX_HEIGHT_DEF);
        repeat (5) send_disparity(pick_disparity());
        set_frame(int'(FOCAL_RST), int'(BASELINE_RST), 1, 2);
        repeat (3) send_disparity(pick_disparity());
    endtask

    // Zero focal length or zero baseline null the coordinates only.
    task automatic test_zero_scale();
        set_frame(0, 1048575, 7, 5);
        send_disparity(16'h0005);
        send_disparity(16'hFFF0);
        set_frame(65535, 0, 7, 5);
        send_disparity(16'h0005);
        send_disparity(16'h0001);
    endtask

    // Largest scale with the smallest disparity: drive Z into saturation,
    // Y in both directions and X in the positive direction.
    task automatic test_saturation();
        set_frame(65535, 1048575, 1, MAX_HEIGHT_DEF);
        send_disparity(16'h0001);
        // Advance the row counter cheaply with invalid pixels.
        repeat (140) send_disparity(pick_nonpositive());
        set_frame(65535, 1048575, 1, 2);
        send_disparity(16'h0001);
        send_disparity(16'h0001);
        set_frame(65535, 1048575, MAX_WIDTH_DEF, 1);
        repeat (140) send_disparity(pick_nonpositive());
        set_frame(65535, 1048575, 1, 1);
        send_disparity(16'h0001);
    endtask

    // Long receiver hold-off while items keep coming, then a full pause,
    // then a burst with no idling at all.
    task automatic test_backpressure();
        int saved_send;
        int saved_recv;
        set_frame($urandom_range(1, 65535), $urandom_range(1, 1048575), 5, 3);
        hold_request = HOLD_CYCLES;
        repeat (12) send_disparity(pick_disparity());
        wait_drained();
        saved_send        = sender_idle_pct;
        saved_recv        = receiver_idle_pct;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        repeat (20) send_disparity(pick_disparity());
        sender_idle_pct   = saved_send;
        receiver_idle_pct = saved_recv;
    endtask

    // Random register settings, each followed by a run of random pixels.
    task automatic test_random_frames(int phases, int per_phase);
        repeat (phases)
        begin
            set_frame(pick_scale(65535), pick_scale(1048575), pick_dim(9), pick_dim(6));
            repeat (per_phase) send_disparity(pick_disparity());
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        focal_q    = FOCAL_RST;
        baseline_q = BASELINE_RST;
        width_q    = WIDTH_RST;
        height_q   = HEIGHT_RST;
        col_pos    = 0;
        row_pos    = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Sender idles rarely, receiver often.
        sender_idle_pct   = 29;
        receiver_idle_pct = 79;
        test_reset_state();
        test_dimension_limits();
        test_zero_scale();
        test_saturation();
        test_backpressure();
        test_random_frames(5, 28);

        // Swap the roles: sender idles often, receiver rarely.
        sender_idle_pct   = 79;
        receiver_idle_pct = 29;
        test_random_frames(5, 28);

        // Full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_frames(5, 28);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Reprojected %0d pixels under %0d register settings: %0d points checked,",
                 pixels_sent, frame_setups, points_checked);
        $display("%0d frame ends, %0d invalid points, %0d saturated points, %0d mismatches",
                 frame_ends, invalid_points, saturated_points, mismatches);
        if (mismatches == 0 && point_queue.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
